>>> rtl/mpool_pkg.sv
// Shared constants of the streaming max pool unit with argmax indices.
// Default sizes, register map codes and field widths; no dependencies.
package mpool_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;
	localparam int unsigned MAX_KERNEL_DEF = 8;
	localparam int unsigned DATA_BITS_DEF  = 16;

	localparam int unsigned ADDR_BITS  = 5;
	localparam int unsigned INDEX_BITS = 20;
	localparam int unsigned POS_BITS   = 10;

	// register map, byte address is 4 * index
	localparam logic [2:0] REG_IN_HEIGHT   = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
	localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
	localparam logic [2:0] REG_KERNEL_COLS = 3'd3;
	localparam logic [2:0] REG_STRIDE_ROWS = 3'd4;
	localparam logic [2:0] REG_STRIDE_COLS = 3'd5;
	localparam logic [2:0] REG_PAD_TOP     = 3'd6;
	localparam logic [2:0] REG_PAD_LEFT    = 3'd7;

	localparam logic [10:0] RST_IN_HEIGHT = 11'd8;
	localparam logic [10:0] RST_IN_WIDTH  = 11'd8;
	localparam logic [3:0]  RST_KERNEL    = 4'd2;
	localparam logic [3:0]  RST_STRIDE    = 4'd2;
	localparam logic [2:0]  RST_PAD       = 3'd0;

	// geometry divider operations
	localparam logic [1:0] OP_OUT_ROWS = 2'd0;
	localparam logic [1:0] OP_OUT_COLS = 2'd1;
	localparam logic [1:0] OP_PAD_ROWS = 2'd2;
	localparam logic [1:0] OP_PAD_COLS = 2'd3;

endpackage

>>> rtl/max_pool_2d_with_argmax_unit.sv
// Top level of the streaming 2-D max pool unit with argmax indices.
// Depends on mpool_pkg; holds the window store memory and its sequencer.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  pixel    | pix_valid, pix_ready, pixel_value         | request in
//  result   | res_valid, res_ready, max_value,          | request out
//           | mask_index, out_row, out_col,             |
//           | last_of_run, plane_done                   |
//  config   | psel, penable, pwrite, paddr, pwdata,     | APB write/read
//           | prdata, pready                            |
//
// After a pixel request is taken, pix_ready stays low while the sequencer
// issues one read-modify-write of the window store per pooling window that
// covers the pixel, one at a time (single store read port); a pixel in no
// window leaves pix_ready high. After reset and every register write a
// serial divider derives output sizes and window trackers, pix_ready low
// meanwhile. A full result register stalls the store pipeline, and with it
// the sequencer, on a window-completing entry until res_ready takes it.
module max_pool_2d_with_argmax_unit #(
	parameter int unsigned MAX_WIDTH  = mpool_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = mpool_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned MAX_KERNEL = mpool_pkg::MAX_KERNEL_DEF,
	parameter int unsigned DATA_BITS  = mpool_pkg::DATA_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [mpool_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  logic                                   pix_valid,
	output logic                                   pix_ready,
	input  logic signed [DATA_BITS-1:0]            pixel_value,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic signed [DATA_BITS-1:0]            max_value,
	output logic [mpool_pkg::INDEX_BITS-1:0]       mask_index,
	output logic [mpool_pkg::POS_BITS-1:0]         out_row,
	output logic [mpool_pkg::POS_BITS-1:0]         out_col,
	output logic                                   last_of_run,
	output logic                                   plane_done
);
	import mpool_pkg::*;

	localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	// signed width for positions, window numbers and geometry
	localparam int AW     = $clog2(MAXDIM + 2 * MAX_KERNEL) + 2;
	localparam int CNT_W  = $clog2(AW);
	localparam int CB     = $clog2(MAX_WIDTH + 2 * MAX_KERNEL);
	localparam int RB     = $clog2(MAX_KERNEL);
	localparam int MEM_AW = RB + CB;
	localparam int DEPTH  = 1 << MEM_AW;
	localparam int ENT_W  = DATA_BITS + INDEX_BITS;

	// configuration registers
	logic [10:0] in_height_q, in_width_q;
	logic [3:0]  kernel_rows_q, kernel_cols_q, stride_rows_q, stride_cols_q;
	logic [2:0]  pad_top_q, pad_left_q;

	// effective geometry
	logic signed [AW-1:0] size_r, size_c, span_r, span_c;
	logic [3:0] k_r, k_c, s_r, s_c;
	logic [2:0] p_r, p_c;

	// geometry divider
	logic             geom_busy_q;
	logic [1:0]       op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    dquo_q;
	logic [3:0]       drem_q;
	logic [AW-1:0]    dnum;
	logic [3:0]       dden;
	logic [4:0]       dr2;
	logic             dge;
	logic [4:0]       drem_n;
	logic [AW-1:0]    dquo_n;
	logic signed [AW-1:0] outn_r_q, outn_c_q, hi0_r_q, hi0_c_q;
	logic [3:0]       rem0_r_q, rem0_c_q;

	// position and window trackers
	logic signed [AW-1:0] h_q, w_q;
	logic [INDEX_BITS-1:0] pix_q;
	logic signed [AW-1:0] lo_r_q, hi_r_q, lo_c_q, hi_c_q;
	logic [3:0] hrem_r_q, hrem_c_q, lcnt_r_q, lcnt_c_q;
	logic signed [AW-1:0] phi_eff, qhi_eff;
	logic empty;

	// window sequencer
	logic                  seq_active_q;
	logic signed [AW-1:0]  seq_ph_q, seq_pw_q, seq_qlo_q, seq_phi_q, seq_qhi_q;
	logic signed [AW-1:0]  seq_h_q, seq_w_q;
	logic signed [DATA_BITS-1:0] seq_v_q;
	logic [INDEX_BITS-1:0] seq_pix_q;
	logic [AW-1:0]         prod_r, prod_c;
	logic signed [AW-1:0]  hs_raw, hs, he_raw, he, ws_raw, ws, we_raw, we;
	logic seed_w, done_w, last_r, last_c, pdone_w;
	logic [MEM_AW-1:0] raddr;

	// store pipeline
	logic                  s1_valid, s1_seed, s1_done, s1_last, s1_pdone;
	logic [MEM_AW-1:0]     s1_addr;
	logic [POS_BITS-1:0]   s1_ph, s1_pw;
	logic signed [DATA_BITS-1:0] s1_v;
	logic [INDEX_BITS-1:0] s1_pix;
	logic [ENT_W-1:0]      rd_data_s1;
	logic                  fwd_v_q;
	logic [MEM_AW-1:0]     fwd_addr_q;
	logic [ENT_W-1:0]      fwd_data_q;
	logic [ENT_W-1:0]      old_ent, new_ent;
	logic signed [DATA_BITS-1:0] old_v;
	logic out_free, s1_adv, issue, wr, cfg_wr, pix_acc;

	logic [ENT_W-1:0] mem [DEPTH];

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign pix_ready = !geom_busy_q && !seq_active_q;
	assign pix_acc = pix_valid && pix_ready;

	// register readback
	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_IN_HEIGHT:   prdata = 32'(in_height_q);
			REG_IN_WIDTH:    prdata = 32'(in_width_q);
			REG_KERNEL_ROWS: prdata = 32'(kernel_rows_q);
			REG_KERNEL_COLS: prdata = 32'(kernel_cols_q);
			REG_STRIDE_ROWS: prdata = 32'(stride_rows_q);
			REG_STRIDE_COLS: prdata = 32'(stride_cols_q);
			REG_PAD_TOP:     prdata = 32'(pad_top_q);
			REG_PAD_LEFT:    prdata = 32'(pad_left_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= RST_IN_HEIGHT;
			in_width_q    <= RST_IN_WIDTH;
			kernel_rows_q <= RST_KERNEL;
			kernel_cols_q <= RST_KERNEL;
			stride_rows_q <= RST_STRIDE;
			stride_cols_q <= RST_STRIDE;
			pad_top_q     <= RST_PAD;
			pad_left_q    <= RST_PAD;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_IN_HEIGHT:   in_height_q   <= pwdata[10:0];
				REG_IN_WIDTH:    in_width_q    <= pwdata[10:0];
				REG_KERNEL_ROWS: kernel_rows_q <= pwdata[3:0];
				REG_KERNEL_COLS: kernel_cols_q <= pwdata[3:0];
				REG_STRIDE_ROWS: stride_rows_q <= pwdata[3:0];
				REG_STRIDE_COLS: stride_cols_q <= pwdata[3:0];
				REG_PAD_TOP:     pad_top_q     <= pwdata[2:0];
				REG_PAD_LEFT:    pad_left_q    <= pwdata[2:0];
				default:         pad_left_q    <= pad_left_q;
			endcase
		end
	end

	// Clamp the raw registers: zero sizes act as one, oversize saturates,
	// pad saturates to kernel minus one.
	always_comb begin
		if (in_height_q == '0) size_r = AW'(1);
		else if (32'(in_height_q) > MAX_HEIGHT) size_r = AW'(MAX_HEIGHT);
		else size_r = AW'(in_height_q);
		if (in_width_q == '0) size_c = AW'(1);
		else if (32'(in_width_q) > MAX_WIDTH) size_c = AW'(MAX_WIDTH);
		else size_c = AW'(in_width_q);
		if (kernel_rows_q == '0) k_r = 4'd1;
		else if (32'(kernel_rows_q) > MAX_KERNEL) k_r = 4'(MAX_KERNEL);
		else k_r = kernel_rows_q;
		if (kernel_cols_q == '0) k_c = 4'd1;
		else if (32'(kernel_cols_q) > MAX_KERNEL) k_c = 4'(MAX_KERNEL);
		else k_c = kernel_cols_q;
		s_r = (stride_rows_q == '0) ? 4'd1 : stride_rows_q;
		s_c = (stride_cols_q == '0) ? 4'd1 : stride_cols_q;
		p_r = ({1'b0, pad_top_q} >= k_r) ? 3'(k_r - 4'd1) : pad_top_q;
		p_c = ({1'b0, pad_left_q} >= k_c) ? 3'(k_c - 4'd1) : pad_left_q;
		span_r = size_r + AW'({p_r, 1'b0}) - AW'(k_r);
		span_c = size_c + AW'({p_c, 1'b0}) - AW'(k_c);
	end

	// One restoring divider step per cycle, shared by the four geometry ops.
	always_comb begin
		unique case (op_q)
			OP_OUT_ROWS: begin
				dnum = (span_r < 0) ? '0 : span_r;
				dden = s_r;
			end
			OP_OUT_COLS: begin
				dnum = (span_c < 0) ? '0 : span_c;
				dden = s_c;
			end
			OP_PAD_ROWS: begin
				dnum = AW'(p_r);
				dden = s_r;
			end
			default: begin
				dnum = AW'(p_c);
				dden = s_c;
			end
		endcase
		dr2    = {drem_q, dnum[cnt_q]};
		dge    = dr2 >= {1'b0, dden};
		drem_n = dge ? (dr2 - {1'b0, dden}) : dr2;
		dquo_n = {dquo_q[AW-2:0], dge};
	end

	// visible windows of this pixel
	always_comb begin
		phi_eff = (hi_r_q > outn_r_q - AW'(1)) ? (outn_r_q - AW'(1)) : hi_r_q;
		qhi_eff = (hi_c_q > outn_c_q - AW'(1)) ? (outn_c_q - AW'(1)) : hi_c_q;
		empty   = (lo_r_q > phi_eff) || (lo_c_q > qhi_eff);
	end

	// geometry, position counters and window trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_busy_q <= 1'b1;
			op_q        <= OP_OUT_ROWS;
			cnt_q       <= CNT_W'(AW - 1);
			dquo_q      <= '0;
			drem_q      <= '0;
			outn_r_q    <= '0;
			outn_c_q    <= '0;
			hi0_r_q     <= '0;
			hi0_c_q     <= '0;
			rem0_r_q    <= '0;
			rem0_c_q    <= '0;
			h_q         <= '0;
			w_q         <= '0;
			pix_q       <= '0;
			lo_r_q      <= '0;
			hi_r_q      <= '0;
			lo_c_q      <= '0;
			hi_c_q      <= '0;
			hrem_r_q    <= '0;
			hrem_c_q    <= '0;
			lcnt_r_q    <= 4'd1;
			lcnt_c_q    <= 4'd1;
		end else if (cfg_wr) begin
			// restart the plane and rederive the geometry
			geom_busy_q <= 1'b1;
			op_q        <= OP_OUT_ROWS;
			cnt_q       <= CNT_W'(AW - 1);
			dquo_q      <= '0;
			drem_q      <= '0;
			h_q         <= '0;
			w_q         <= '0;
			pix_q       <= '0;
		end else if (geom_busy_q) begin
			if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				dquo_q <= dquo_n;
				drem_q <= drem_n[3:0];
			end else begin
				cnt_q  <= CNT_W'(AW - 1);
				dquo_q <= '0;
				drem_q <= '0;
				op_q   <= op_q + 2'd1;
				unique case (op_q)
					OP_OUT_ROWS: outn_r_q <= (span_r < 0) ? '0 : $signed(dquo_n) + AW'(1);
					OP_OUT_COLS: outn_c_q <= (span_c < 0) ? '0 : $signed(dquo_n) + AW'(1);
					OP_PAD_ROWS: begin
						hi0_r_q  <= $signed(dquo_n);
						rem0_r_q <= drem_n[3:0];
					end
					default: begin
						hi0_c_q     <= $signed(dquo_n);
						rem0_c_q    <= drem_n[3:0];
						geom_busy_q <= 1'b0;
						lo_r_q      <= '0;
						hi_r_q      <= hi0_r_q;
						hrem_r_q    <= rem0_r_q;
						lcnt_r_q    <= k_r - 4'(p_r);
						lo_c_q      <= '0;
						hi_c_q      <= $signed(dquo_n);
						hrem_c_q    <= drem_n[3:0];
						lcnt_c_q    <= k_c - 4'(p_c);
					end
				endcase
			end
		end else if (pix_acc) begin
			if (w_q + AW'(1) == size_c) begin
				// end of row: rewind the column tracker
				w_q      <= '0;
				lo_c_q   <= '0;
				hi_c_q   <= hi0_c_q;
				hrem_c_q <= rem0_c_q;
				lcnt_c_q <= k_c - 4'(p_c);
				if (h_q + AW'(1) == size_r) begin
					h_q      <= '0;
					pix_q    <= '0;
					lo_r_q   <= '0;
					hi_r_q   <= hi0_r_q;
					hrem_r_q <= rem0_r_q;
					lcnt_r_q <= k_r - 4'(p_r);
				end else begin
					h_q   <= h_q + AW'(1);
					pix_q <= pix_q + INDEX_BITS'(1);
					if (hrem_r_q + 4'd1 == s_r) begin
						hrem_r_q <= '0;
						hi_r_q   <= hi_r_q + AW'(1);
					end else begin
						hrem_r_q <= hrem_r_q + 4'd1;
					end
					if (lcnt_r_q == 4'd1) begin
						lo_r_q   <= lo_r_q + AW'(1);
						lcnt_r_q <= s_r;
					end else begin
						lcnt_r_q <= lcnt_r_q - 4'd1;
					end
				end
			end else begin
				w_q   <= w_q + AW'(1);
				pix_q <= pix_q + INDEX_BITS'(1);
				if (hrem_c_q + 4'd1 == s_c) begin
					hrem_c_q <= '0;
					hi_c_q   <= hi_c_q + AW'(1);
				end else begin
					hrem_c_q <= hrem_c_q + 4'd1;
				end
				if (lcnt_c_q == 4'd1) begin
					lo_c_q   <= lo_c_q + AW'(1);
					lcnt_c_q <= s_c;
				end else begin
					lcnt_c_q <= lcnt_c_q - 4'd1;
				end
			end
		end
	end

	// Window bounds of the current sequencer entry, clipped to the plane.
	always_comb begin
		prod_r  = seq_ph_q * AW'(s_r);
		prod_c  = seq_pw_q * AW'(s_c);
		hs_raw  = $signed(prod_r) - $signed(AW'(p_r));
		ws_raw  = $signed(prod_c) - $signed(AW'(p_c));
		hs      = (hs_raw < 0) ? '0 : hs_raw;
		ws      = (ws_raw < 0) ? '0 : ws_raw;
		he_raw  = hs_raw + AW'(k_r);
		we_raw  = ws_raw + AW'(k_c);
		he      = (he_raw > size_r) ? size_r : he_raw;
		we      = (we_raw > size_c) ? size_c : we_raw;
		seed_w  = (seq_h_q == hs) && (seq_w_q == ws);
		done_w  = (seq_h_q == he - AW'(1)) && (seq_w_q == we - AW'(1));
		// completing windows form a prefix of the range; only on the last
		// row or column can more than one of them complete
		last_r  = (seq_h_q == size_r - AW'(1)) ? (seq_ph_q == seq_phi_q) : 1'b1;
		last_c  = (seq_w_q == size_c - AW'(1)) ? (seq_pw_q == seq_qhi_q) : 1'b1;
		pdone_w = (seq_ph_q == outn_r_q - AW'(1)) && (seq_pw_q == outn_c_q - AW'(1));
		raddr   = {seq_ph_q[RB-1:0], seq_pw_q[CB-1:0]};
	end

	// store pipeline control and read-modify-write with forwarding
	always_comb begin
		out_free = !res_valid || res_ready;
		s1_adv   = !s1_valid || !s1_done || out_free;
		issue    = seq_active_q && s1_adv;
		wr       = s1_valid && s1_adv;
		old_ent  = (fwd_v_q && fwd_addr_q == s1_addr) ? fwd_data_q : rd_data_s1;
		old_v    = old_ent[ENT_W-1:INDEX_BITS];
		new_ent  = (s1_seed || s1_v > old_v) ? {s1_v, s1_pix} : old_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_active_q <= 1'b0;
			s1_valid     <= 1'b0;
			fwd_v_q      <= 1'b0;
			res_valid    <= 1'b0;
		end else begin
			if (pix_acc) begin
				seq_active_q <= !empty;
			end else if (issue && seq_pw_q == seq_qhi_q && seq_ph_q == seq_phi_q) begin
				seq_active_q <= 1'b0;
			end
			if (s1_adv) begin
				s1_valid <= issue;
			end
			if (wr) begin
				fwd_v_q <= 1'b1;
			end
			if (wr && s1_done) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// sequencer payload
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			seq_ph_q  <= lo_r_q;
			seq_pw_q  <= lo_c_q;
			seq_qlo_q <= lo_c_q;
			seq_phi_q <= phi_eff;
			seq_qhi_q <= qhi_eff;
			seq_h_q   <= h_q;
			seq_w_q   <= w_q;
			seq_v_q   <= pixel_value;
			seq_pix_q <= pix_q;
		end else if (issue) begin
			if (seq_pw_q == seq_qhi_q) begin
				seq_pw_q <= seq_qlo_q;
				seq_ph_q <= seq_ph_q + AW'(1);
			end else begin
				seq_pw_q <= seq_pw_q + AW'(1);
			end
		end
		if (issue) begin
			s1_addr  <= raddr;
			s1_seed  <= seed_w;
			s1_done  <= done_w;
			s1_last  <= done_w && last_r && last_c;
			s1_pdone <= done_w && pdone_w;
			s1_ph    <= seq_ph_q[POS_BITS-1:0];
			s1_pw    <= seq_pw_q[POS_BITS-1:0];
			s1_v     <= seq_v_q;
			s1_pix   <= seq_pix_q;
		end
		if (wr) begin
			fwd_addr_q <= s1_addr;
			fwd_data_q <= new_ent;
		end
		if (wr && s1_done) begin
			max_value   <= new_ent[ENT_W-1:INDEX_BITS];
			mask_index  <= new_ent[INDEX_BITS-1:0];
			out_row     <= s1_ph;
			out_col     <= s1_pw;
			last_of_run <= s1_last;
			plane_done  <= s1_pdone;
		end
	end

	// window store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[s1_addr] <= new_ent;
		end
		if (issue) begin
			rd_data_s1 <= mem[raddr];
		end
	end

endmodule

>>> tb/tb_max_pool_2d_with_argmax_unit.sv
// Self-checking testbench of max_pool_2d_with_argmax_unit: pixel requests in
// raster order, pooled results checked against an in-bench window predictor.
// Depends on mpool_pkg and the unit RTL.
module tb_max_pool_2d_with_argmax_unit;
	import mpool_pkg::*;

	localparam int KMAX      = 8;
	localparam int ROW_SLOTS = 1024 + 2 * KMAX;

	typedef struct {
		logic signed [15:0] value;
		logic [19:0]        index;
		logic [9:0]         row;
		logic [9:0]         col;
		logic               last;
		logic               done;
	} pool_result_t;

	typedef struct {
		int sz, k, s, p, outn;
	} axis_geom_t;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               pix_valid;
	logic               pix_ready;
	logic signed [15:0] pixel_value;
	logic               res_valid;
	logic               res_ready;
	logic signed [15:0] max_value;
	logic [19:0]        mask_index;
	logic [9:0]         out_row, out_col;
	logic               last_of_run, plane_done;

	// shadow registers and raster position of the predictor
	logic [10:0] sh_height, sh_width;
	logic [3:0]  sh_krows, sh_kcols, sh_srows, sh_scols;
	logic [2:0]  sh_ptop, sh_pleft;
	int          next_row, next_col;

	// running max and argmax per open window
	int          win_max [KMAX*ROW_SLOTS];
	int unsigned win_arg [KMAX*ROW_SLOTS];

	pool_result_t pending_results[$];
	int  mismatches;
	bit  quiet;
	int  pixels_sent;
	int  res_stall;

	max_pool_2d_with_argmax_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pixel_value(pixel_value),
		.res_valid(res_valid), .res_ready(res_ready), .max_value(max_value),
		.mask_index(mask_index), .out_row(out_row), .out_col(out_col),
		.last_of_run(last_of_run), .plane_done(plane_done)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Derive clamped geometry of one axis: zero sizes act as one, oversize
	// planes and kernels saturate, pad saturates to kernel minus one.
	function automatic axis_geom_t axis_geom(int sz, int k, int s, int p);
		axis_geom_t a;
		int span;
		a.sz = (sz < 1) ? 1 : (sz > 1024 ? 1024 : sz);
		a.k  = (k < 1) ? 1 : (k > KMAX ? KMAX : k);
		a.s  = (s < 1) ? 1 : s;
		a.p  = (p > a.k - 1) ? a.k - 1 : p;
		span = a.sz + 2 * a.p - a.k;
		a.outn = (span < 0) ? 0 : span / a.s + 1;
		return a;
	endfunction

	// Fold one accepted pixel into every window that covers it and queue the
	// results of the windows it completes, in raster order.
	function automatic void pool_pixel(logic signed [15:0] v);
		axis_geom_t ay, ax;
		int h, w, t, rlo, rhi, clo, chi, hs, he, ws, we, slot, first;
		logic [19:0] pix;
		pool_result_t r;
		ay = axis_geom(sh_height, sh_krows, sh_srows, sh_ptop);
		ax = axis_geom(sh_width, sh_kcols, sh_scols, sh_pleft);
		h = next_row;
		w = next_col;
		pix = 20'(h * ax.sz + w);
		first = pending_results.size();
		if (h >= ay.sz || w >= ax.sz) begin
			h = 0;
			w = 0;
		end
		t = h + ay.p + 1 - ay.k;
		rlo = (t <= 0) ? 0 : (t + ay.s - 1) / ay.s;
		rhi = (h + ay.p) / ay.s;
		if (rhi > ay.outn - 1) rhi = ay.outn - 1;
		t = w + ax.p + 1 - ax.k;
		clo = (t <= 0) ? 0 : (t + ax.s - 1) / ax.s;
		chi = (w + ax.p) / ax.s;
		if (chi > ax.outn - 1) chi = ax.outn - 1;
		for (int ph = rlo; ph <= rhi; ph++) begin
			hs = ph * ay.s - ay.p;
			he = hs + ay.k;
			if (he > ay.sz) he = ay.sz;
			if (hs < 0) hs = 0;
			for (int pw = clo; pw <= chi; pw++) begin
				ws = pw * ax.s - ax.p;
				we = ws + ax.k;
				if (we > ax.sz) we = ax.sz;
				if (ws < 0) ws = 0;
				slot = (ph % KMAX) * ROW_SLOTS + pw;
				// the window's first pixel seeds it; later only strictly greater wins
				if ((h == hs && w == ws) || int'(v) > win_max[slot]) begin
					win_max[slot] = v;
					win_arg[slot] = pix;
				end
				if (h == he - 1 && w == we - 1) begin
					r.value = 16'(win_max[slot]);
					r.index = 20'(win_arg[slot]);
					r.row   = 10'(ph);
					r.col   = 10'(pw);
					r.last  = 1'b0;
					r.done  = (ph == ay.outn - 1 && pw == ax.outn - 1);
					pending_results.insert(pending_results.size(), r);
				end
			end
		end
		if (pending_results.size() > first)
			pending_results[pending_results.size()-1].last = 1'b1;
		w++;
		if (w >= ax.sz) begin
			w = 0;
			h++;
			if (h >= ay.sz) h = 0;
		end
		next_row = h;
		next_col = w;
	endfunction

	// Write one register over APB; any write also restarts the plane.
	task automatic reg_write(logic [2:0] idx, int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_IN_HEIGHT:   sh_height = 11'(val);
			REG_IN_WIDTH:    sh_width  = 11'(val);
			REG_KERNEL_ROWS: sh_krows  = 4'(val);
			REG_KERNEL_COLS: sh_kcols  = 4'(val);
			REG_STRIDE_ROWS: sh_srows  = 4'(val);
			REG_STRIDE_COLS: sh_scols  = 4'(val);
			REG_PAD_TOP:     sh_ptop   = 3'(val);
			default:         sh_pleft  = 3'(val);
		endcase
		next_row = 0;
		next_col = 0;
	endtask

	task automatic set_geometry(int hh, int ww, int kr, int kc, int sr, int sc,
			int pt, int pl);
		reg_write(REG_IN_HEIGHT, hh);
		reg_write(REG_IN_WIDTH, ww);
		reg_write(REG_KERNEL_ROWS, kr);
		reg_write(REG_KERNEL_COLS, kc);
		reg_write(REG_STRIDE_ROWS, sr);
		reg_write(REG_STRIDE_COLS, sc);
		reg_write(REG_PAD_TOP, pt);
		reg_write(REG_PAD_LEFT, pl);
	endtask

	// Send one pixel request. Valid stays high on return so a back-to-back
	// request needs no toggle; callers that pause drop it themselves.
	task automatic send_pixel(logic signed [15:0] v);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		pix_valid   <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (!pix_ready);
		pool_pixel(v);
		pixels_sent++;
	endtask

	// Drop valid, wait for every expected result, then let the store pipeline
	// settle, since pixels in no window leave nothing to wait on.
	task automatic drain;
		pix_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send_plane;
		axis_geom_t ay, ax;
		ay = axis_geom(sh_height, sh_krows, sh_srows, sh_ptop);
		ax = axis_geom(sh_width, sh_kcols, sh_scols, sh_pleft);
		repeat (ay.sz * ax.sz) send_pixel(16'($urandom));
		drain();
	endtask

	// Default geometry straight out of reset: 8x8 plane, 2x2 windows.
	task automatic test_reset_defaults;
		send_plane();
	endtask

	// Extreme values, ties (first max must win) and overlapping padded windows.
	task automatic test_value_extremes;
		logic signed [15:0] vals[16];
		vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
			16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
			16'sh0001, 16'sh0000, 16'shFFFF, 16'sh7FFE,
			16'sh8001, 16'sh8000, 16'sh5555, 16'shAAAA};
		set_geometry(4, 4, 2, 3, 1, 2, 1, 2);
		foreach (vals[i]) send_pixel(vals[i]);
		drain();
		// all-equal plane: every index must point at the window's first pixel
		set_geometry(3, 3, 2, 2, 1, 1, 0, 0);
		repeat (9) send_pixel(16'sh8000);
		drain();
	endtask

	task automatic test_special_geometry;
		// zero sizes act as one
		set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
		send_pixel(16'sh1234);
		drain();
		// oversize kernel saturates; pad is one below the saturated kernel
		set_geometry(3, 4, 15, 9, 3, 8, 7, 7);
		send_plane();
		// plane smaller than kernel: no windows, nothing emitted
		set_geometry(2, 3, 8, 8, 1, 1, 0, 0);
		send_plane();
		// oversize plane saturates; a partial plane is cut by the next write
		set_geometry(2047, 2047, 1, 1, 1, 1, 0, 0);
		repeat (5) send_pixel(16'($urandom));
		drain();
		set_geometry(1100, 3, 2, 1, 1, 1, 1, 0);
		repeat (7) send_pixel(16'($urandom));
		drain();
	endtask

	// Random geometries on small planes; the last phases run without idling.
	task automatic test_random_planes;
		int start;
		start = pixels_sent;
		while (pixels_sent - start < 90) begin
			if (pixels_sent - start > 60) quiet = 1'b1;
			set_geometry($urandom_range(1, 6), $urandom_range(1, 8),
				$urandom_range(1, 9), $urandom_range(1, 9),
				$urandom_range(1, 9), $urandom_range(1, 9),
				$urandom_range(0, 7), $urandom_range(0, 7));
			send_plane();
		end
	endtask

	// Result side: random stall bursts, none once the run goes quiet.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			res_stall <= 0;
		end else if (quiet) begin
			res_ready <= 1'b1;
		end else if (res_stall > 0) begin
			res_stall <= res_stall - 1;
			res_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			res_stall <= $urandom_range(0, 13);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		pool_result_t e;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: max %0d idx %0d row %0d col %0d",
						max_value, mask_index, out_row, out_col);
			end else begin
				e = pending_results.pop_front();
				if (max_value !== e.value || mask_index !== e.index ||
						out_row !== e.row || out_col !== e.col ||
						last_of_run !== e.last || plane_done !== e.done) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp max %0d idx %0d row %0d col %0d last %0b done %0b",
							e.value, e.index, e.row, e.col, e.last, e.done);
						$display("          got max %0d idx %0d row %0d col %0d last %0b done %0b",
							max_value, mask_index, out_row, out_col,
							last_of_run, plane_done);
					end
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pix_valid   = 1'b0;
		pixel_value = '0;
		mismatches  = 0;
		quiet       = 1'b0;
		pixels_sent = 0;
		sh_height = RST_IN_HEIGHT; sh_width = RST_IN_WIDTH;
		sh_krows  = RST_KERNEL;    sh_kcols = RST_KERNEL;
		sh_srows  = RST_STRIDE;    sh_scols = RST_STRIDE;
		sh_ptop   = RST_PAD;       sh_pleft = RST_PAD;
		next_row  = 0;
		next_col  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_value_extremes();
		test_special_geometry();
		test_random_planes();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("max_pool_2d_with_argmax_unit test passed");
		else
			$display("max_pool_2d_with_argmax_unit test failed");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#(8 * 1000000);
		$display("max_pool_2d_with_argmax_unit test failed");
		$finish;
	end

endmodule
